/* hw/rtl/dcw_pkg.sv */
// Package for the date check and weekday block: payload structs, calendar
// constants and small calendar functions. No dependencies.
package dcw_pkg;

  localparam logic [15:0] SWITCH_YEAR = 16'd1752;
  // floor(x / 25) = (x * RECIP_25) >> RECIP_SHIFT, exact for 14-bit x
  localparam logic [12:0] RECIP_25    = 13'd5243;
  localparam int          RECIP_SHIFT = 17;
  // Leap-year count offset after the switch (438 Julian minus 425 Gregorian)
  localparam logic [15:0] LEAP_OFFSET = 16'd13;
  localparam logic [6:0]  SKIP_DAYS   = 7'd11;
  localparam logic [3:0]  MONTH_FEB   = 4'd2;
  localparam logic [3:0]  MONTH_SEP   = 4'd9;

  typedef struct packed {
    logic [3:0]  month_in;
    logic [5:0]  day_in;
    logic [15:0] year_in;
  } date_in_t;

  typedef struct packed {
    logic       date_valid;
    logic [2:0] weekday;
  } date_out_t;

  // Days in a month, common year; zero for codes that are not months
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before the month in a common year, modulo 7
  function automatic logic [2:0] days_before_mod7(input logic [3:0] m);
    logic [2:0] r;
    case (m)
      4'd3:    r = 3'd3;
      4'd4:    r = 3'd6;
      4'd5:    r = 3'd1;
      4'd6:    r = 3'd4;
      4'd7:    r = 3'd6;
      4'd8:    r = 3'd2;
      4'd9:    r = 3'd5;
      4'd11:   r = 3'd3;
      4'd12:   r = 3'd5;
      4'd2:    r = 3'd3;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // x mod 7 by folding octal digits (8 = 1 mod 7)
  function automatic logic [2:0] mod7(input logic [15:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = {3'b0, x[2:0]} + {3'b0, x[5:3]} + {3'b0, x[8:6]} + {3'b0, x[11:9]}
       + {3'b0, x[14:12]} + {5'b0, x[15]};
    s2 = {1'b0, s1[5:3]} + {1'b0, s1[2:0]};
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[2:0];
  endfunction

endpackage

/* hw/rtl/dcw_if.sv */
// Valid/ready channel carrying one payload word per handshake.
// Payload type is a parameter; used with the structs of dcw_pkg.
interface dcw_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/date_check_and_weekday.sv */
// Date check and weekday: validity test and day of week for one date per word.
// Depends on dcw_pkg and the dcw_if channel interface.
//
// Usage:
//   date   - sink channel, one word = month_in, day_in, year_in.
//   result - source channel, one word = date_valid, weekday (0 = Sunday).
//   Years through 1752 use Julian leap rules, later years Gregorian; the dates
//   3..13 September 1752 do not exist. Invalid dates give weekday 0.
// Pipeline: four register stages from acceptance to result valid:
//   (year-1)/4 times the reciprocal of 25; leap count and month length check;
//   mod 7 reduction of each term; final sum mod 7 into the output register.
// Throughput: one date per cycle while the receiver takes results.
// Stall: each stage holds its word when the next one is full and blocked, so
//   a stalled receiver fills the pipe and then drops date.ready; bubbles are
//   squeezed out, and nothing is lost or repeated.
// Reset: rst (synchronous, active high) empties all stages; no results are
//   pending afterward and date.ready is high in the next cycle.
module date_check_and_weekday (
  input  logic clk,
  input  logic rst,
  dcw_if.sink   date,
  dcw_if.source result
);
  import dcw_pkg::*;

  typedef struct packed {
    logic [3:0]  m;
    logic [5:0]  d;
    logic [15:0] y;
    logic [15:0] n;
    logic [13:0] q4;
    logic [26:0] prod;
    logic        base_ok;
    logic        pre;
  } st1_t;

  typedef struct packed {
    logic [3:0]  m;
    logic [5:0]  d;
    logic [15:0] n;
    logic [15:0] leaps;
    logic        leap;
    logic        ok;
    logic        pre;
  } st2_t;

  typedef struct packed {
    logic [2:0] n_mod;
    logic [2:0] l_mod;
    logic [2:0] s_mod;
    logic       ok;
  } st3_t;

  logic      v1, v2, v3, v4;
  logic      r1, r2, r3, r4;
  st1_t      s1, s1_next;
  st2_t      s2, s2_next;
  st3_t      s3, s3_next;
  date_out_t s4, s4_next;

  // Per-stage ready: a stage takes a word when empty or draining
  assign r4 = !v4 || result.ready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign date.ready   = r1;
  assign result.valid = v4;
  assign result.data  = s4;

  // Stage 1: range checks, year - 1, and (year-1)/4 times reciprocal of 25
  always_comb begin
    s1_next.m    = date.data.month_in;
    s1_next.d    = date.data.day_in;
    s1_next.y    = date.data.year_in;
    s1_next.n    = date.data.year_in - 16'd1;
    s1_next.q4   = s1_next.n[15:2];
    s1_next.prod = {13'b0, s1_next.q4} * {14'b0, RECIP_25};
    s1_next.base_ok = (date.data.month_in >= 4'd1) && (date.data.month_in <= 4'd12)
        && (date.data.day_in != 6'd0) && (date.data.year_in != 16'd0)
        && !((date.data.year_in == SWITCH_YEAR) && (date.data.month_in == MONTH_SEP)
             && (date.data.day_in > 6'd2) && (date.data.day_in < 6'd14));
    s1_next.pre = (date.data.year_in < SWITCH_YEAR)
        || ((date.data.year_in == SWITCH_YEAR)
            && ((date.data.month_in < MONTH_SEP)
                || ((date.data.month_in == MONTH_SEP) && (date.data.day_in < 6'd3))));
  end

  // Stage 2: leap count through year-1, leap test of year, month length check
  always_comb begin
    logic [9:0]  q100;
    logic [7:0]  q400;
    logic [15:0] rem100;
    logic [4:0]  mlen;
    logic        mult4;
    q100   = s1.prod[RECIP_SHIFT +: 10];
    q400   = q100[9:2];
    rem100 = s1.n - ({q100, 6'b0} + {1'b0, q100, 5'b0} + {4'b0, q100, 2'b0});
    mult4  = (s1.y[1:0] == 2'b00);
    s2_next.m   = s1.m;
    s2_next.d   = s1.d;
    s2_next.n   = s1.n;
    s2_next.pre = s1.pre;
    if (s1.y <= SWITCH_YEAR) begin
      s2_next.leap = mult4;
    end else begin
      // year%100 == 0 iff (year-1)%100 == 99; year%400 also needs (year-1)/100 = 3 mod 4
      s2_next.leap = mult4 && ((rem100 != 16'd99) || (q100[1:0] == 2'd3));
    end
    if (s1.n <= SWITCH_YEAR) begin
      s2_next.leaps = {2'b0, s1.q4};
    end else begin
      s2_next.leaps = LEAP_OFFSET + {2'b0, s1.q4} - {6'b0, q100} + {8'b0, q400};
    end
    mlen = month_len(s1.m) + {4'b0, (s1.m == MONTH_FEB) && s2_next.leap};
    s2_next.ok = s1.base_ok && ({1'b0, s1.d} <= {2'b0, mlen});
  end

  // Stage 3: reduce each term of the day count modulo 7
  always_comb begin
    logic [6:0] small_sum;
    small_sum = 7'd1 + {4'b0, days_before_mod7(s2.m)}
              + {6'b0, (s2.m > MONTH_FEB) && s2.leap}
              + {1'b0, s2.d} + (s2.pre ? SKIP_DAYS : 7'd0);
    s3_next.n_mod = mod7(s2.n);
    s3_next.l_mod = mod7(s2.leaps);
    s3_next.s_mod = mod7({9'b0, small_sum});
    s3_next.ok    = s2.ok;
  end

  // Stage 4: final sum modulo 7
  always_comb begin
    logic [4:0] tsum;
    tsum = {2'b0, s3.n_mod} + {2'b0, s3.l_mod} + {2'b0, s3.s_mod};
    s4_next.date_valid = s3.ok;
    s4_next.weekday    = s3.ok ? mod7({11'b0, tsum}) : 3'd0;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= date.valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (r1) s1 <= s1_next;
    if (r2) s2 <= s2_next;
    if (r3) s3 <= s3_next;
    if (r4) s4 <= s4_next;
  end

`ifndef SYNTHESIS
  a_invalid_weekday_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.data.date_valid) |-> (result.data.weekday == 3'd0))
    else $error("invalid date with nonzero weekday");

  a_weekday_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.data.weekday != 3'd7))
    else $error("weekday out of range");

  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (rst)
    (date.valid && date.ready) |=> v1)
    else $error("accepted date did not enter stage 1");

  a_stage4_hold: assert property (@(posedge clk) disable iff (rst)
    (v4 && !result.ready) |=> (v4 && $stable(s4)))
    else $error("output stage changed while stalled");
`endif

endmodule

/* dv/tb_date_check_and_weekday.sv */
// Testbench for date_check_and_weekday: random and directed dates go in, and a
// scoreboard predicts validity and weekday for every accepted word.
// Depends on dcw_pkg, the dcw_if channel interface and the block itself.
module tb_date_check_and_weekday;
  import dcw_pkg::*;

  // One pending prediction: the date that was taken and the word it must give
  typedef struct {
    date_in_t  src;
    date_out_t exp;
  } day_entry_t;

  // Scoreboard: calendar predictor plus the queue of expected result words
  class weekday_scoreboard;
    day_entry_t  pending_days[$];
    int unsigned n_dates;
    int unsigned n_valid;
    int unsigned n_invalid;
    int unsigned n_errors;

    function int unsigned days_in_month(int unsigned m);
      case (m)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11:           return 30;
        2:                     return 28;
        default:               return 0;
      endcase
    endfunction

    // Days of the months before m in a common year
    function int unsigned days_ahead(int unsigned m);
      int unsigned acc;
      acc = 0;
      for (int unsigned k = 1; k < m; k++) begin
        acc += days_in_month(k);
      end
      return acc;
    endfunction

    // Julian rule through the switch year, Gregorian after it
    function bit is_leap(int unsigned y);
      if (y <= SWITCH_YEAR) begin
        return (y % 4) == 0;
      end
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    // Leap years among 1..n; 438 Julian leaps through 1752, Gregorian count after
    function int unsigned leaps_upto(int unsigned n);
      if (n <= SWITCH_YEAR) begin
        return n / 4;
      end
      return 438 + (n / 4 - n / 100 + n / 400) - 425;
    endfunction

    function date_out_t expected_day(date_in_t w);
      int unsigned m, d, y, mlen, total;
      date_out_t   r;
      m = w.month_in;
      d = w.day_in;
      y = w.year_in;
      r = '0;
      if (m < 1 || m > 12 || d < 1 || y < 1) begin
        return r;
      end
      // days dropped at the calendar switch
      if (y == SWITCH_YEAR && m == MONTH_SEP && d > 2 && d < 14) begin
        return r;
      end
      mlen = days_in_month(m) + ((m == MONTH_FEB && is_leap(y)) ? 1 : 0);
      if (d > mlen) begin
        return r;
      end
      total = 1 + 365 * (y - 1) + leaps_upto(y - 1) + days_ahead(m) + d;
      if (m > MONTH_FEB && is_leap(y)) begin
        total += 1;
      end
      if (y < SWITCH_YEAR || (y == SWITCH_YEAR && (m < MONTH_SEP ||
          (m == MONTH_SEP && d < 3)))) begin
        total += SKIP_DAYS;
      end
      r.date_valid = 1'b1;
      r.weekday    = 3'(total % 7);
      return r;
    endfunction

    function void note_date(date_in_t w);
      day_entry_t e;
      e.src = w;
      e.exp = expected_day(w);
      pending_days.push_back(e);
      n_dates++;
    endfunction

    function void check_result(date_out_t got);
      day_entry_t e;
      if (pending_days.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) begin
          $display("ERROR: result word %0b/%0d with no date pending",
                   got.date_valid, got.weekday);
        end
        return;
      end
      e = pending_days.pop_front();
      if (got.date_valid !== e.exp.date_valid || got.weekday !== e.exp.weekday) begin
        n_errors++;
        if (n_errors <= 10) begin
          $display("ERROR: %0d/%0d/%0d valid exp %0b got %0b, weekday exp %0d got %0d",
                   e.src.month_in, e.src.day_in, e.src.year_in, e.exp.date_valid,
                   got.date_valid, e.exp.weekday, got.weekday);
        end
      end
      if (e.exp.date_valid) begin
        n_valid++;
      end else begin
        n_invalid++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_days.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   full_rate;

  dcw_if #(.payload_t(date_in_t))  date_ch ();
  dcw_if #(.payload_t(date_out_t)) result_ch ();

  weekday_scoreboard sb = new();

  date_check_and_weekday u_top (
    .clk    (clk),
    .rst    (rst),
    .date   (date_ch),
    .result (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  initial begin
    #(12 * 1000000);
    $display("== FAIL ==");
    $finish;
  end

  // Monitor both channels at the clock edge
  always @(posedge clk) begin
    if (!rst) begin
      if (date_ch.valid && date_ch.ready) begin
        sb.note_date(date_ch.data);
      end
      if (result_ch.valid && result_ch.ready) begin
        sb.check_result(result_ch.data);
      end
    end
  end

  // Receiver: ready runs with short stalls and a few long ones, or stays high at full rate
  initial begin
    int unsigned r, n;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (full_rate) begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          result_ch.ready <= 1'b1;
          n = $urandom_range(1, 8);
        end else if (r < 95) begin
          result_ch.ready <= 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          result_ch.ready <= 1'b0;
          n = $urandom_range(15, 40);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic date_in_t make_date(int unsigned m, int unsigned d, int unsigned y);
    date_in_t w;
    w.month_in = 4'(m);
    w.day_in   = 6'(d);
    w.year_in  = 16'(y);
    return w;
  endfunction

  // Mostly plausible dates near month ends and the switch year, some noise
  function automatic date_in_t random_date();
    int unsigned m, d, y, r;
    if ($urandom_range(0, 99) < 20) begin
      return make_date($urandom_range(0, 15), $urandom_range(0, 63),
                       $urandom_range(0, 65535));
    end
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2: y = $urandom_range(1740, 1765);
      3, 4:    y = $urandom_range(1, 3000);
      5:       y = $urandom_range(1, 10);
      6:       y = $urandom_range(0, 65535);
      7:       y = 100 * $urandom_range(1, 655);
      default: y = $urandom_range(65530, 65535);
    endcase
    m = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
    d = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 28) : $urandom_range(28, 32);
    if (y == SWITCH_YEAR && $urandom_range(0, 3) == 0) begin
      m = MONTH_SEP;
      d = $urandom_range(1, 15);
    end
    return make_date(m, d, y);
  endfunction

  // Present one date word and hold it until taken, then idle for a random gap (none at full rate)
  task automatic send_date(date_in_t w);
    int unsigned gap;
    date_ch.valid <= 1'b1;
    date_ch.data  <= w;
    do @(posedge clk); while (!date_ch.ready);
    gap = full_rate ? 0 : pick_gap();
    if (gap > 0) begin
      date_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending until every expected result word is back
  task automatic drain_results();
    date_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    rst           <= 1'b1;
    full_rate      = 1'b0;
    date_ch.valid <= 1'b0;
    date_ch.data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, leap rules on both sides, the skipped days
    send_date(make_date(0, 1, 2000));
    send_date(make_date(13, 1, 2000));
    send_date(make_date(15, 63, 65535));
    send_date(make_date(1, 0, 2000));
    send_date(make_date(1, 63, 2000));
    send_date(make_date(1, 1, 0));
    send_date(make_date(1, 1, 1));
    send_date(make_date(12, 31, 65535));
    send_date(make_date(2, 29, 1700));
    send_date(make_date(2, 29, 1800));
    send_date(make_date(2, 29, 1900));
    send_date(make_date(2, 29, 2000));
    send_date(make_date(2, 29, 1752));
    send_date(make_date(2, 30, 1752));
    send_date(make_date(9, 2, 1752));
    send_date(make_date(9, 3, 1752));
    send_date(make_date(9, 13, 1752));
    send_date(make_date(9, 14, 1752));
    send_date(make_date(12, 31, 1751));
    send_date(make_date(12, 31, 1752));
    send_date(make_date(1, 1, 1753));
    send_date(make_date(4, 30, 2024));
    send_date(make_date(4, 31, 2024));
    send_date(make_date(8, 42, 1066));
    drain_results();

    // Random batches; one at full rate, a drain between each
    for (int b = 0; b < 5; b++) begin
      full_rate = (b == 2);
      for (int i = 0; i < 250; i++) begin
        send_date(random_date());
      end
      drain_results();
    end
    full_rate = 1'b0;

    repeat (10) @(posedge clk);
    $display("Sent %0d date words: %0d valid, %0d invalid; %0d mismatches",
             sb.n_dates, sb.n_valid, sb.n_invalid, sb.n_errors);
    if (sb.n_errors == 0 && sb.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
